@@ src/dq_pkg.sv @@
// shared types and constants of the double-ended queue
package dq_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int BUF_DEPTH = 4;
  localparam int BUF_PTR_W = 2;
  localparam int BUF_CNT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_FRONT = 3'd4,
    OP_READ_BACK  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic                      last;
  } result_t;

endpackage

@@ src/dq_if.sv @@
// request and response channel interfaces of the double-ended queue
interface dq_req_if;
  import dq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [STATUS_W-1:0]       status;
  logic                      last;

  modport source (output valid, result_value, status, last, input ready);
  modport sink (input valid, result_value, status, last, output ready);
endinterface

@@ src/dq_out_buf.sv @@
// four-word result buffer in front of the response channel
module dq_out_buf (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  dq_pkg::result_t                wr_data,
  output logic [dq_pkg::BUF_CNT_W-1:0]   count,
  dq_rsp_if.source                       rsp
);
  import dq_pkg::*;

  result_t              entries [BUF_DEPTH];
  logic [BUF_PTR_W-1:0] head;
  logic [BUF_PTR_W-1:0] tail;
  logic                 pop;

  assign pop              = rsp.valid && rsp.ready;
  assign rsp.valid        = (count != '0);
  assign rsp.result_value = entries[head].value;
  assign rsp.status       = entries[head].status;
  assign rsp.last         = entries[head].last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + BUF_CNT_W'(wr_en) - BUF_CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= BUF_CNT_W'(BUF_DEPTH))
    else $error("result buffer count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count < BUF_CNT_W'(BUF_DEPTH)))
    else $error("word written into a full result buffer");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !wr_en) |=> (count == $past(count) - 1'b1))
    else $error("result buffer count did not drop on pop");
`endif

endmodule

@@ src/double_ended_queue_top.sv @@
// double-ended queue of signed words in a ring memory, top level
// Usage:
//   req carries one operation per word: push front/back, pop front/back, or
//   read out every entry front-first or back-first; rsp returns results.
//   A push or pop gives one result word; a read-out gives one per stored
//   entry with last set on the final one; an empty pop or read-out gives an
//   underflow word, a push into a full queue an overflow word.
//   Pushes and pops are taken one per cycle while req.ready is high; each
//   result is registered in the memory read and pending registers, then
//   in the result buffer, before it appears on rsp.
//   A read-out holds off req until all N stored entries are read: one read
//   of the ring memory per cycle while the buffer has room, set by the single read port.
//   Results queue in a four-word buffer; req.ready drops during a read-out
//   and when that buffer could overflow, so a stalled rsp stalls req after
//   a few words and never loses or repeats a word.
//   Reset empties the queue and the buffer; no clearing pass is needed and
//   req is ready as soon as reset is released.
module double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);
  import dq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  state_t           state, state_next;
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic             rd_back, rd_back_next;

  logic                  pend;
  logic                  pend_mem;
  status_t               pend_status;
  logic                  pend_last;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  iss, iss_mem, iss_last;
  status_t               iss_status;
  logic                  re, we;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      off;
  logic [IDX_W:0]        ring_sum;
  logic [IDX_W-1:0]      ring_addr;
  logic [IDX_W-1:0]      front_dec, front_inc, cnt_low, cnt_last;
  logic [63:0]           wr_wide, rd_wide;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  full, empty, credit, acc, rd_final;
  op_t                   op;
  logic [BUF_CNT_W-1:0]  buf_count;
  result_t               buf_data;

  assign op        = op_t'(req.operation);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign credit    = (buf_count + BUF_CNT_W'(pend)) < BUF_CNT_W'(BUF_DEPTH);
  assign req.ready = (state == ST_IDLE) && credit;
  assign acc       = req.valid && req.ready;

  assign cnt_low   = count[IDX_W-1:0];
  assign cnt_last  = IDX_W'(count - 1'b1);
  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign rd_final  = (rd_idx == cnt_last);

  // ring offset from the front entry
  always_comb begin
    off = '0;
    if (state == ST_READ) begin
      off = rd_back ? cnt_last - rd_idx : rd_idx;
    end else begin
      case (op)
        OP_PUSH_BACK: off = cnt_low;
        OP_POP_BACK:  off = cnt_last;
        default:      off = '0;
      endcase
    end
  end

  assign ring_sum  = {1'b0, front} + {1'b0, off};
  assign ring_addr = (ring_sum >= (IDX_W + 1)'(DEPTH)) ?
                     IDX_W'(ring_sum - (IDX_W + 1)'(DEPTH)) : ring_sum[IDX_W-1:0];

  assign wr_wide = {32'b0, req.value};
  assign wr_data = wr_wide[DATA_WIDTH-1:0];

  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    rd_idx_next  = rd_idx;
    rd_back_next = rd_back;
    iss          = 1'b0;
    iss_mem      = 1'b0;
    iss_status   = STAT_OK;
    iss_last     = 1'b1;
    re           = 1'b0;
    we           = 1'b0;
    wr_addr      = ring_addr;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              iss = 1'b1;
              if (full) begin
                iss_status = STAT_OVER;
              end else begin
                we         = 1'b1;
                count_next = count + 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  wr_addr    = front_dec;
                  front_next = front_dec;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              iss = 1'b1;
              if (empty) begin
                iss_status = STAT_UNDER;
              end else begin
                re         = 1'b1;
                iss_mem    = 1'b1;
                count_next = count - 1'b1;
                if (op == OP_POP_FRONT) begin
                  front_next = front_inc;
                end
              end
            end
            OP_READ_FRONT, OP_READ_BACK: begin
              if (empty) begin
                iss        = 1'b1;
                iss_status = STAT_UNDER;
              end else begin
                state_next   = ST_READ;
                rd_idx_next  = '0;
                rd_back_next = (op == OP_READ_BACK);
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (credit) begin
          re          = 1'b1;
          iss         = 1'b1;
          iss_mem     = 1'b1;
          iss_last    = rd_final;
          rd_idx_next = rd_idx + 1'b1;
          if (rd_final) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[ring_addr];
    end
  end

  always_ff @(posedge clk) begin
    pend_mem    <= iss_mem;
    pend_status <= iss_status;
    pend_last   <= iss_last;
    rd_idx      <= rd_idx_next;
    rd_back     <= rd_back_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      pend  <= iss;
    end
  end

  assign rd_wide         = 64'(rd_data);
  assign buf_data.value  = pend_mem ? rd_wide[VALUE_W-1:0] : '0;
  assign buf_data.status = pend_status;
  assign buf_data.last   = pend_last;

  dq_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (pend),
    .wr_data (buf_data),
    .count   (buf_count),
    .rsp     (rsp)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !req.ready)
    else $error("request taken during read-out");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (acc && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)) |=>
      (count == $past(count) && front == $past(front)))
    else $error("push into full queue changed state");

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(re && we))
    else $error("memory read and write in one cycle");
`endif

endmodule

@@ dv/double_ended_queue_top_tb.sv @@
// testbench of the double-ended queue: random operations checked against a tracked deque
`timescale 1ns / 1ps

import dq_pkg::*;

class deque_tracker;
  int unsigned               slots;
  logic signed [VALUE_W-1:0] ring[];
  int unsigned               head;
  int unsigned               fill;
  result_t                   pending[$];
  int unsigned               failures;

  function new(int unsigned depth);
    slots    = depth;
    ring     = new[depth];
    head     = 0;
    fill     = 0;
    failures = 0;
  endfunction

  function void queue_result(logic signed [VALUE_W-1:0] val, status_t st, logic fin);
    result_t r;
    r.value  = val;
    r.status = st;
    r.last   = fin;
    pending.push_back(r);
  endfunction

  function void flag(string what);
    failures++;
    if (failures <= 10) $display("mismatch: %s", what);
  endfunction

  // works out every result word that one accepted request word causes
  function void note_request(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val);
    int unsigned i;
    int unsigned pos;
    case (op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill == slots) begin
          queue_result('0, STAT_OVER, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head = (head + slots - 1) % slots;
            ring[head] = val;
          end else begin
            ring[(head + fill) % slots] = val;
          end
          fill++;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill == 0) begin
          queue_result('0, STAT_UNDER, 1'b1);
        end else begin
          if (op == OP_POP_FRONT) begin
            queue_result(ring[head], STAT_OK, 1'b1);
            head = (head + 1) % slots;
          end else begin
            queue_result(ring[(head + fill - 1) % slots], STAT_OK, 1'b1);
          end
          fill--;
        end
      end
      OP_READ_FRONT, OP_READ_BACK: begin
        if (fill == 0) begin
          queue_result('0, STAT_UNDER, 1'b1);
        end else begin
          for (i = 0; i < fill; i++) begin
            pos = (op == OP_READ_FRONT) ? i : fill - 1 - i;
            queue_result(ring[(head + pos) % slots], STAT_OK, (i + 1 == fill));
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function void check_result(logic signed [VALUE_W-1:0] val, logic [STATUS_W-1:0] st,
                             logic fin);
    result_t want;
    if (pending.size() == 0) begin
      flag($sformatf("unexpected word value=%0d status=%0d last=%0b", val, st, fin));
    end else begin
      want = pending.pop_front();
      if (val !== want.value || st !== want.status || fin !== want.last)
        flag($sformatf("expected value=%0d status=%0d last=%0b, got value=%0d status=%0d last=%0b",
                       want.value, want.status, want.last, val, st, fin));
    end
  endfunction

  function bit clean();
    if (pending.size() != 0) flag($sformatf("%0d words never arrived", pending.size()));
    return failures == 0;
  endfunction
endclass

module double_ended_queue_top_tb;

  localparam int          DQ_DEPTH     = 16;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 24;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk;
  logic rst;

  dq_req_if req ();
  dq_rsp_if rsp ();

  double_ended_queue_top #(
    .DEPTH      (DQ_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  deque_tracker tracker;
  int unsigned  cycle_count;
  bit           sender_quiet;
  bit           receiver_quiet;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1)
      tracker.check_result(rsp.result_value, rsp.status, rsp.last);
  end

  // result side: random stall before each word, with quiet stretches
  initial begin
    int unsigned stall;
    int unsigned taken;
    rsp.ready = 1'b0;
    taken = 0;
    forever begin
      if (taken % 32 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      stall = receiver_quiet ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk);
        rsp.ready <= 1'b0;
      end
      @(negedge clk);
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid === 1'b1 && !rst));
      taken++;
    end
  end

  task automatic drive_word(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val);
    @(negedge clk);
    req.valid     <= 1'b1;
    req.operation <= op;
    req.value     <= val;
    do @(posedge clk); while (req.ready !== 1'b1);
    tracker.note_request(op, val);
  endtask

  task automatic issue(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    drive_word(op, val);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // empty queue underflows on every removal and read-out
    issue(OP_POP_FRONT, 32'sd5);
    issue(OP_POP_BACK, 32'sd6);
    issue(OP_READ_FRONT, 32'sd7);
    issue(OP_READ_BACK, 32'sd8);
    issue(OP_PUSH_FRONT, 32'sh7fffffff);
    issue(OP_PUSH_BACK, 32'sh80000000);
    issue(OP_PUSH_FRONT, 32'sd0);
    issue(OP_PUSH_BACK, -32'sd1);
    issue(OP_READ_FRONT, 32'sd0);
    issue(OP_READ_BACK, 32'sd0);
    issue(OP_SPARE_LO, 32'sd11);
    issue(OP_SPARE_HI, 32'sd12);
    issue(OP_POP_FRONT, 32'sd0);
    issue(OP_POP_BACK, 32'sd0);
    issue(OP_POP_FRONT, 32'sd0);
    // removing the only entry empties the queue
    issue(OP_POP_BACK, 32'sd0);
    issue(OP_POP_FRONT, 32'sd0);
    issue(OP_PUSH_BACK, 32'shaaaaaaaa);
    issue(OP_PUSH_FRONT, 32'sh55555555);
    issue(OP_READ_BACK, 32'sd0);
    issue(OP_POP_BACK, 32'sd0);
    issue(OP_READ_FRONT, 32'sd0);
    issue(OP_POP_FRONT, 32'sd0);
    issue(OP_READ_BACK, 32'sd0);
  endtask

  task automatic run_random(int unsigned target);
    int unsigned               done;
    int unsigned               spot;
    int unsigned               mode;
    int unsigned               roll;
    int unsigned               push_edge;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] val;
    done = 0;
    spot = 0;
    mode = 0;
    while (done < target) begin
      // fill, drain and mixed phases so the full and empty ends are both reached
      if (spot % 24 == 0) begin
        mode         = $urandom_range(0, 2);
        sender_quiet = ($urandom_range(0, 3) == 0);
      end
      if (spot % 100 == 99) drain_results();
      spot++;
      push_edge = (mode == 0) ? 75 : (mode == 1) ? 30 : 56;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      else if (roll < 13)
        op = $urandom_range(0, 1) ? OP_READ_BACK : OP_READ_FRONT;
      else if (roll < push_edge)
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      case ($urandom_range(0, 19))
        0:       val = 32'sh7fffffff;
        1:       val = 32'sh80000000;
        2:       val = 32'sd0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase
      issue(op, val);
      if (op != OP_SPARE_LO && op != OP_SPARE_HI) done++;
    end
  endtask

  initial begin
    tracker       = new(DQ_DEPTH);
    cycle_count   = 0;
    sender_quiet  = 1'b0;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.operation = '0;
    req.value     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    drain_results();
    run_random(410);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.clean())
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
